[hdl/rar_pkg.sv]
// Package for the rational arithmetic reduce block.
// Holds the opcode and sequencer state types and the fixed result width.
package rar_pkg;

    localparam int OUT_BITS = 33;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GSTART,
        ST_GSTEP,
        ST_GWAIT,
        ST_QN,
        ST_QNW,
        ST_QD,
        ST_QDW,
        ST_NEXT,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FIN
    } t_state;

    typedef logic [1:0] t_pass;

endpackage

[hdl/rar_in_if.sv]
// Valid/ready channel interfaces for operands and results.
// Depends on rar_pkg for the result width.
interface rar_in_if #(parameter int OPERAND_BITS = 16);
    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic [OPERAND_BITS-1:0] a_num;
    logic [OPERAND_BITS-1:0] a_den;
    logic [OPERAND_BITS-1:0] b_num;
    logic [OPERAND_BITS-1:0] b_den;
    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rar_out_if;
    logic                         valid;
    logic                         ready;
    logic [rar_pkg::OUT_BITS-1:0] res_num;
    logic [rar_pkg::OUT_BITS-1:0] res_den;
    logic                         bad_den;
    modport source (output valid, res_num, res_den, bad_den, input ready);
    modport sink   (input valid, res_num, res_den, bad_den, output ready);
endinterface

[hdl/rar_div.sv]
// Shared restoring divider, one quotient bit per cycle, truncating signed.
// No package dependency; width set by the instantiating module.
module rar_div #(
    parameter int W = 34
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_dividend,
    input  logic signed [W-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic signed [W-1:0] o_quo,
    output logic signed [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, r_q, r_dv;
    logic [CW-1:0] r_cnt;
    logic          r_sq, r_sr, r_busy, r_done;
    logic [W:0]    w_sh, w_tr;
    logic [W-1:0]  w_abs_a, w_abs_b;

    // magnitudes of the operands
    assign w_abs_a = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
    assign w_abs_b = i_divisor[W-1]  ? W'(-i_divisor)  : W'(i_divisor);

    // trial subtract of the shifted partial remainder
    assign w_sh = {r_acc, r_q[W-1]};
    assign w_tr = w_sh - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load magnitudes, then one bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_acc <= '0;
            r_q   <= w_abs_a;
            r_dv  <= w_abs_b;
            r_sq  <= i_dividend[W-1] ^ i_divisor[W-1];
            r_sr  <= i_dividend[W-1];
        end else if (r_busy) begin
            if (!w_tr[W]) begin
                r_acc <= w_tr[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b1};
            end else begin
                r_acc <= w_sh[W-1:0];
                r_q   <= {r_q[W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_sq ? -$signed(r_q)   : $signed(r_q);
    assign o_rem  = r_sr ? -$signed(r_acc) : $signed(r_acc);

endmodule

[hdl/rational_arith_reduce.sv]
// Top level: sequencer, operand registers and multiplier around rar_div.
// Depends on rar_pkg, rar_in_if / rar_out_if and rar_div.
//
// Usage: one beat on i_in carries an opcode (add, subtract, multiply,
// divide) and two raw fractions. Each operand is reduced by the signed
// Euclid gcd, the operation runs on a single shared multiplier through the
// MUL0, MUL1 and MUL2 states, and the result is reduced twice more. One
// beat on o_out carries the reduced numerator, denominator and the
// zero-denominator flag. Each Euclid remainder step and each quotient
// uses the shared serial divider. There are four reductions, and each one
// whose values are both nonzero ends with two quotients (up to eight in
// all). i_in.ready is high only while the sequencer is idle. A finished
// result is held in the output register; the next item may be accepted
// meanwhile, and its result waits in the final state until the receiver
// takes the earlier beat.
// Reset clears the sequencer, the divider control and the output valid.
module rational_arith_reduce #(
    parameter int OPERAND_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rar_in_if.sink    i_in,
    rar_out_if.source o_out
);
    localparam int W  = 2 * OPERAND_BITS + 2;
    localparam int MW = OPERAND_BITS + 1;
    localparam int XW = (W > rar_pkg::OUT_BITS) ? W : rar_pkg::OUT_BITS;

    rar_pkg::t_state r_state, n_state;
    rar_pkg::t_pass  r_pass;
    rar_pkg::t_cmd   r_cmd;

    logic signed [W-1:0] r_n, r_d, r_x, r_y;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic                r_ov, r_bad;
    logic [rar_pkg::OUT_BITS-1:0] r_on, r_od;

    logic                w_start, w_busy, w_done;
    logic signed [W-1:0] w_dvd, w_dvs, w_quo, w_rem;
    logic signed [MW-1:0] w_mx, w_my;
    logic signed [W-1:0] w_prod;
    logic                w_load_out;
    logic signed [XW-1:0] w_ext_n, w_ext_d;

    rar_div #(.W(W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rar_pkg::ST_IDLE:   if (i_in.valid) n_state = rar_pkg::ST_GSTART;
            rar_pkg::ST_GSTART: begin
                if (r_n == '0 || r_d == '0) n_state = rar_pkg::ST_NEXT;
                else                        n_state = rar_pkg::ST_GSTEP;
            end
            rar_pkg::ST_GSTEP:  n_state = rar_pkg::ST_GWAIT;
            rar_pkg::ST_GWAIT: begin
                if (w_done) begin
                    if (w_rem == '0) n_state = rar_pkg::ST_QN;
                    else             n_state = rar_pkg::ST_GSTEP;
                end
            end
            rar_pkg::ST_QN:     n_state = rar_pkg::ST_QNW;
            rar_pkg::ST_QNW:    if (w_done) n_state = rar_pkg::ST_QD;
            rar_pkg::ST_QD:     n_state = rar_pkg::ST_QDW;
            rar_pkg::ST_QDW:    if (w_done) n_state = rar_pkg::ST_NEXT;
            rar_pkg::ST_NEXT: begin
                case (r_pass)
                    2'd1:    n_state = rar_pkg::ST_MUL0;
                    2'd3:    n_state = rar_pkg::ST_FIN;
                    default: n_state = rar_pkg::ST_GSTART;
                endcase
            end
            rar_pkg::ST_MUL0:   n_state = rar_pkg::ST_MUL1;
            rar_pkg::ST_MUL1:   n_state = rar_pkg::ST_MUL2;
            rar_pkg::ST_MUL2:   n_state = rar_pkg::ST_GSTART;
            rar_pkg::ST_FIN:    if (!r_ov || o_out.ready) n_state = rar_pkg::ST_IDLE;
            default:            n_state = rar_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: divider issue and multiplier operand select
    always_comb begin
        w_start    = 1'b0;
        w_dvd      = r_x;
        w_dvs      = r_y;
        w_mx       = r_an[MW-1:0];
        w_my       = r_bd[MW-1:0];
        w_load_out = 1'b0;
        case (r_state)
            rar_pkg::ST_GSTEP: w_start = 1'b1;
            rar_pkg::ST_QN: begin
                w_start = 1'b1;
                w_dvd   = r_n;
                w_dvs   = r_x;
            end
            rar_pkg::ST_QD: begin
                w_start = 1'b1;
                w_dvd   = r_d;
                w_dvs   = r_x;
            end
            rar_pkg::ST_MUL0: begin
                if (r_cmd == rar_pkg::CMD_MUL) w_my = r_bn[MW-1:0];
            end
            rar_pkg::ST_MUL1: begin
                w_mx = r_ad[MW-1:0];
                w_my = r_bn[MW-1:0];
            end
            rar_pkg::ST_MUL2: begin
                w_mx = r_ad[MW-1:0];
                if (r_cmd == rar_pkg::CMD_DIV) w_my = r_bn[MW-1:0];
            end
            rar_pkg::ST_FIN: w_load_out = !r_ov || o_out.ready;
            default: ;
        endcase
    end

    assign w_prod = W'(w_mx * w_my);

    // advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rar_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            rar_pkg::ST_IDLE: begin
                r_cmd  <= rar_pkg::t_cmd'(i_in.cmd);
                r_n    <= W'($signed(i_in.a_num));
                r_d    <= W'($signed(i_in.a_den));
                r_bn   <= W'($signed(i_in.b_num));
                r_bd   <= W'($signed(i_in.b_den));
                r_pass <= 2'd0;
            end
            rar_pkg::ST_GSTART: begin
                if (r_d > r_n) begin
                    r_x <= r_d;
                    r_y <= r_n;
                end else begin
                    r_x <= r_n;
                    r_y <= r_d;
                end
            end
            rar_pkg::ST_GWAIT: begin
                if (w_done) begin
                    r_x <= r_y;
                    r_y <= w_rem;
                end
            end
            rar_pkg::ST_QNW: if (w_done) r_n <= w_quo;
            rar_pkg::ST_QDW: if (w_done) r_d <= w_quo;
            rar_pkg::ST_NEXT: begin
                r_pass <= r_pass + 2'd1;
                if (r_pass == 2'd0) begin
                    r_an <= r_n;
                    r_ad <= r_d;
                    r_n  <= r_bn;
                    r_d  <= r_bd;
                end else if (r_pass == 2'd1) begin
                    r_bn <= r_n;
                    r_bd <= r_d;
                end
            end
            rar_pkg::ST_MUL0: r_n <= w_prod;
            rar_pkg::ST_MUL1: begin
                if (r_cmd == rar_pkg::CMD_ADD)      r_n <= r_n + w_prod;
                else if (r_cmd == rar_pkg::CMD_SUB) r_n <= r_n - w_prod;
            end
            rar_pkg::ST_MUL2: r_d <= w_prod;
            default: ;
        endcase
    end

    // output register, held until the receiver takes the beat
    assign w_ext_n = XW'(r_n);
    assign w_ext_d = XW'(r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_on  <= w_ext_n[rar_pkg::OUT_BITS-1:0];
            r_od  <= w_ext_d[rar_pkg::OUT_BITS-1:0];
            r_bad <= (r_ad == '0) || (r_bd == '0) || (r_d == '0);
        end
    end

    assign i_in.ready    = (r_state == rar_pkg::ST_IDLE);
    assign o_out.valid   = r_ov;
    assign o_out.res_num = r_on;
    assign o_out.res_den = r_od;
    assign o_out.bad_den = r_bad;

    // divider is only issued while idle
    a_div_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> !w_busy)
        else $error("divider issued while busy");

    // a divider result only arrives in a wait state
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == rar_pkg::ST_GWAIT || r_state == rar_pkg::ST_QNW
                    || r_state == rar_pkg::ST_QDW))
        else $error("divider result outside a wait state");

    // a loaded result is presented on the next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> o_out.valid)
        else $error("result loaded but not presented");

endmodule
